// ----- src/sbf3_pkg.sv -----
// Shared types and register codes for the clamped 3D box fold core.
package sbf3_pkg;

  typedef struct packed {
    logic weighted;
    logic colour_en;
    logic rescale;
    logic fold_z;
  } sbf3_mode_t;

  typedef enum logic [2:0] {
    REG_FOLD_X,
    REG_FOLD_Y,
    REG_FOLD_Z,
    REG_MODE,
    REG_SCALE,
    REG_COL_X,
    REG_COL_Y,
    REG_COL_Z
  } sbf3_reg_t;

  localparam logic [63:0] FOLD_RESET  = 64'h0100_0000_0200_0000;
  localparam logic [63:0] SCALE_RESET = 64'h0100_0000_0000_0000;
  localparam sbf3_mode_t  MODE_RESET  = '{weighted: 1'b0, colour_en: 1'b0,
                                          rescale: 1'b0, fold_z: 1'b1};

endpackage

// ----- src/sbf3_axis_lane.sv -----
// One axis lane: clamped fold of a coordinate and its colour term.
module sbf3_axis_lane #(
  parameter int W = 32,
  parameter int F = 24,
  localparam int TW = (W > 32) ? W : 32
) (
  input  logic                    clk,
  input  logic signed [W-1:0]     v,
  input  logic signed [31:0]      f,
  input  logic signed [31:0]      m,
  input  logic signed [31:0]      k,
  input  logic                    fold_en,
  input  sbf3_pkg::sbf3_mode_t    mode,
  output logic signed [W-1:0]     newv,
  output logic signed [TW-1:0]    term
);
  import sbf3_pkg::*;

  localparam int EW = TW + 4;
  localparam int PW = EW + 32;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0]  v1, v2, v3, n4, n5, n6, n7;
  logic signed [EW-1:0] sp, sm, t2, d3, w5;
  logic signed [PW-1:0] p6;
  logic                 c4, c5, c6;
  logic signed [TW-1:0] term7;

  logic signed [EW-1:0] ad, r, abs_n;
  logic                 r_fits, s_fits;
  logic signed [W-1:0]  r_sat, wt;
  logic signed [PW-1:0] sh;

  function automatic logic signed [EW-1:0] mag(input logic signed [EW-1:0] x);
    mag = x[EW-1] ? -x : x;
  endfunction

  always_comb begin
    ad = mag(EW'(v2) - t2);
    if (v3 == '0) begin
      r = EW'(v3);
    end else if (v3[W-1]) begin
      r = EW'(v3) + d3;
    end else begin
      r = EW'(v3) - d3;
    end
    r_fits = (&r[EW-1:W-1]) | ~(|r[EW-1:W-1]);
    r_sat  = r_fits ? r[W-1:0] : (r[EW-1] ? VMIN : VMAX);
    abs_n  = mag(EW'(n4));
    sh     = p6 >>> F;
    s_fits = (&sh[PW-1:W-1]) | ~(|sh[PW-1:W-1]);
    wt     = s_fits ? sh[W-1:0] : (sh[PW-1] ? VMIN : VMAX);
  end

  always_ff @(posedge clk) begin
    v1 <= v;
    sp <= EW'(v) + EW'(f);
    sm <= EW'(v) - EW'(f);
    t2 <= mag(sp) - mag(sm) - EW'(v1);
    v2 <= v1;
    d3 <= (EW'(m) < ad) ? EW'(m) : ad;
    v3 <= v2;
    n4 <= fold_en ? r_sat : v3;
    c4 <= fold_en && (r_sat != v3);
    w5 <= abs_n - EW'(f);
    n5 <= n4;
    c5 <= c4;
    p6 <= PW'(k) * PW'(w5);
    n6 <= n5;
    c6 <= c5;
    if (!mode.colour_en || !c6) begin
      term7 <= '0;
    end else if (mode.weighted) begin
      term7 <= TW'(wt);
    end else begin
      term7 <= TW'(k);
    end
    n7 <= n6;
  end

  assign newv = n7;
  assign term = term7;

endmodule

// ----- src/sbf3_scale.sv -----
// Distance estimate rescale path, delayed to line up with the axis lanes.
module sbf3_scale #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                clk,
  input  logic signed [W-1:0] de,
  input  logic signed [31:0]  scale,
  input  logic signed [31:0]  offset,
  input  logic                rescale,
  output logic signed [W-1:0] est
);
  localparam int TW  = (W > 32) ? W : 32;
  localparam int PW  = W + 32;
  localparam int SW  = TW + 1;
  localparam int DLY = 4;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [PW-1:0] p1, sh;
  logic signed [W-1:0]  d1, d2, q2, e3, q_sat, s_sat;
  logic signed [SW-1:0] s;
  logic                 q_fits, s_fits;
  logic signed [W-1:0]  dly [DLY];

  always_comb begin
    sh     = p1 >>> F;
    q_fits = (&sh[PW-1:W-1]) | ~(|sh[PW-1:W-1]);
    q_sat  = q_fits ? sh[W-1:0] : (sh[PW-1] ? VMIN : VMAX);
    s      = SW'(q2) + SW'(offset);
    s_fits = (&s[SW-1:W-1]) | ~(|s[SW-1:W-1]);
    s_sat  = s_fits ? s[W-1:0] : (s[SW-1] ? VMIN : VMAX);
  end

  always_ff @(posedge clk) begin
    p1 <= PW'(de) * PW'(scale);
    d1 <= de;
    q2 <= q_sat;
    d2 <= d1;
    e3 <= rescale ? s_sat : d2;
    dly[0] <= e3;
    for (int i = 1; i < DLY; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  assign est = dly[DLY-1];

endmodule

// ----- src/sbf3_merge.sv -----
// Merge stage: adds the lane colour terms to the input colour when enabled and registers all outputs.
module sbf3_merge #(
  parameter int W = 32,
  localparam int TW = (W > 32) ? W : 32
) (
  input  logic                 clk,
  input  logic signed [W-1:0]  col,
  input  logic signed [W-1:0]  nx,
  input  logic signed [W-1:0]  ny,
  input  logic signed [W-1:0]  nz,
  input  logic signed [TW-1:0] tx,
  input  logic signed [TW-1:0] ty,
  input  logic signed [TW-1:0] tz,
  input  logic signed [W-1:0]  est,
  input  logic                 colour_en,
  output logic signed [W-1:0]  out_x,
  output logic signed [W-1:0]  out_y,
  output logic signed [W-1:0]  out_z,
  output logic signed [W-1:0]  estimate_out,
  output logic signed [W-1:0]  colour_out
);
  localparam int SW = TW + 2;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [SW-1:0] sum;
  logic                 fits;
  logic signed [W-1:0]  sum_sat;

  always_comb begin
    sum     = SW'(col) + SW'(tx) + SW'(ty) + SW'(tz);
    fits    = (&sum[SW-1:W-1]) | ~(|sum[SW-1:W-1]);
    sum_sat = fits ? sum[W-1:0] : (sum[SW-1] ? VMIN : VMAX);
  end

  always_ff @(posedge clk) begin
    out_x        <= nx;
    out_y        <= ny;
    out_z        <= nz;
    estimate_out <= est;
    colour_out   <= colour_en ? sum_sat : col;
  end

endmodule

// ----- src/surface_box_fold_3d_core.sv -----
// Top level of the clamped 3D box fold core: registers, lanes and merge.
//
// Input channel: a point (in_x, in_y, in_z), estimate_in and colour_in are
// taken at each rising edge where start is high and busy is low. busy is
// always low, so a new point may be started every cycle.
// Result channel: done is high for exactly one cycle with out_x, out_y,
// out_z, estimate_out and colour_out valid in that cycle; the receiver
// must take it then. Throughput is one point per cycle. The depth is set
// by the fold chain (sum, difference, clamp, subtract) followed by the
// colour multiplier of each axis lane and the merge adder.
// Configuration: APB port, 64-bit registers at byte address 8*i. Write
// registers only while no point is in flight.
// Reset: rst clears the pipeline valid bits and restores the register
// defaults (fold 1.0, clamp 2.0, z fold on, unit scale, zero factors).
module surface_box_fold_3d_core #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] in_x,
  input  logic signed [VALUE_WIDTH-1:0] in_y,
  input  logic signed [VALUE_WIDTH-1:0] in_z,
  input  logic signed [VALUE_WIDTH-1:0] estimate_in,
  input  logic signed [VALUE_WIDTH-1:0] colour_in,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] out_x,
  output logic signed [VALUE_WIDTH-1:0] out_y,
  output logic signed [VALUE_WIDTH-1:0] out_z,
  output logic signed [VALUE_WIDTH-1:0] estimate_out,
  output logic signed [VALUE_WIDTH-1:0] colour_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [5:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import sbf3_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int TW  = (W > 32) ? W : 32;
  localparam int LAT = 8;
  localparam int CD  = 7;

  logic [63:0]  fold_x, fold_y, fold_z, scale_off;
  logic [31:0]  colour_x, colour_y, colour_z;
  sbf3_mode_t   mode_q;
  sbf3_reg_t    reg_idx;
  logic         wr;

  logic [LAT-1:0]      vld;
  logic signed [W-1:0] col_d [CD];
  logic signed [W-1:0] nx, ny, nz, est;
  logic signed [TW-1:0] tx, ty, tz;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = sbf3_reg_t'(paddr[5:3]);
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_x    <= FOLD_RESET;
      fold_y    <= FOLD_RESET;
      fold_z    <= FOLD_RESET;
      scale_off <= SCALE_RESET;
      mode_q    <= MODE_RESET;
      colour_x  <= '0;
      colour_y  <= '0;
      colour_z  <= '0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_FOLD_X: fold_x    <= pwdata;
        REG_FOLD_Y: fold_y    <= pwdata;
        REG_FOLD_Z: fold_z    <= pwdata;
        REG_MODE:   mode_q    <= sbf3_mode_t'(pwdata[3:0]);
        REG_SCALE:  scale_off <= pwdata;
        REG_COL_X:  colour_x  <= pwdata[31:0];
        REG_COL_Y:  colour_y  <= pwdata[31:0];
        REG_COL_Z:  colour_z  <= pwdata[31:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FOLD_X: prdata = fold_x;
      REG_FOLD_Y: prdata = fold_y;
      REG_FOLD_Z: prdata = fold_z;
      REG_MODE:   prdata = 64'(mode_q);
      REG_SCALE:  prdata = scale_off;
      REG_COL_X:  prdata = 64'(colour_x);
      REG_COL_Y:  prdata = 64'(colour_y);
      REG_COL_Z:  prdata = 64'(colour_z);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    col_d[0] <= colour_in;
    for (int i = 1; i < CD; i++) begin
      col_d[i] <= col_d[i-1];
    end
  end

  assign done = vld[LAT-1];

  sbf3_axis_lane #(.W(W), .F(FRACTION_BITS)) u_lane_x (
    .clk(clk), .v(in_x), .f($signed(fold_x[63:32])), .m($signed(fold_x[31:0])),
    .k($signed(colour_x)), .fold_en(1'b1), .mode(mode_q), .newv(nx), .term(tx)
  );

  sbf3_axis_lane #(.W(W), .F(FRACTION_BITS)) u_lane_y (
    .clk(clk), .v(in_y), .f($signed(fold_y[63:32])), .m($signed(fold_y[31:0])),
    .k($signed(colour_y)), .fold_en(1'b1), .mode(mode_q), .newv(ny), .term(ty)
  );

  sbf3_axis_lane #(.W(W), .F(FRACTION_BITS)) u_lane_z (
    .clk(clk), .v(in_z), .f($signed(fold_z[63:32])), .m($signed(fold_z[31:0])),
    .k($signed(colour_z)), .fold_en(mode_q.fold_z), .mode(mode_q), .newv(nz),
    .term(tz)
  );

  sbf3_scale #(.W(W), .F(FRACTION_BITS)) u_scale (
    .clk(clk), .de(estimate_in), .scale($signed(scale_off[63:32])),
    .offset($signed(scale_off[31:0])), .rescale(mode_q.rescale), .est(est)
  );

  sbf3_merge #(.W(W)) u_merge (
    .clk(clk), .col(col_d[CD-1]), .nx(nx), .ny(ny), .nz(nz),
    .tx(tx), .ty(ty), .tz(tz), .est(est), .colour_en(mode_q.colour_en),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .estimate_out(estimate_out), .colour_out(colour_out)
  );

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result strobe without a start transfer");

  a_colour_pass: assert property (@(posedge clk) disable iff (rst)
    done && !$past(mode_q.colour_en) |-> colour_out == $past(colour_in, LAT))
    else $error("colour altered while colour disabled");

  a_z_pass: assert property (@(posedge clk) disable iff (rst)
    done && !$past(mode_q.fold_z, 5) |-> out_z == $past(in_z, LAT))
    else $error("z altered while z fold disabled");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the clamped 3D box fold core: directed table, then random points.
module testbench;
  import sbf3_pkg::*;

  localparam int          FRACTION_BITS = 24;
  localparam int          LATENCY       = 8;
  localparam int          RANDOM_POINTS = 2000;
  localparam int          SEGMENTS      = 4;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          REPORT_LIMIT  = 100;
  localparam longint      VMAX          = 64'sh7FFF_FFFF;
  localparam longint      VMIN          = -VMAX - 1;
  localparam logic [31:0] Q_ONE         = 32'h0100_0000;
  localparam logic [31:0] Q_NEG_ONE     = 32'hFF00_0000;
  localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN         = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] estimate;
    logic [31:0] colour;
  } point_t;

  typedef struct packed {
    logic [2:0][63:0] fold;
    sbf3_mode_t       mode;
    logic [63:0]      scale;
    logic [2:0][31:0] factor;
  } settings_t;

  typedef struct {
    int     preset;
    bit     typed;
    point_t stim;
    point_t want;
  } directed_row_t;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  logic [31:0] in_x    = '0;
  logic [31:0] in_y    = '0;
  logic [31:0] in_z    = '0;
  logic [31:0] estimate_in = '0;
  logic [31:0] colour_in   = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [5:0]  paddr   = '0;
  logic [63:0] pwdata  = '0;
  logic        busy;
  logic        done;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [31:0] estimate_out;
  logic [31:0] colour_out;
  logic [63:0] prdata;
  logic        pready;

  settings_t     fold_settings;
  settings_t     presets[4];
  point_t        expected_points[$];
  directed_row_t directed_rows[$];
  int            idle_pct       = 0;
  int            errors         = 0;
  int            points_sent    = 0;
  int            points_checked = 0;
  int            settings_loaded = 0;
  int            cycle_count    = 0;

  surface_box_fold_3d_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_z         (in_z),
    .estimate_in  (estimate_in),
    .colour_in    (colour_in),
    .done         (done),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .estimate_out (estimate_out),
    .colour_out   (colour_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint widen(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint magnitude(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clip(input logic signed [127:0] v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return longint'(v);
  endfunction

  function automatic longint fixed_mul(input longint a, input longint b);
    logic signed [127:0] wa, wb, prod;
    wa = a;
    wb = b;
    prod = wa * wb;
    return clip(prod >>> FRACTION_BITS);
  endfunction

  function automatic longint fold_coord(input longint v, input longint f, input longint m);
    longint t, d, s;
    t = magnitude(v + f) - magnitude(v - f) - v;
    d = magnitude(v - t);
    if (m < d) d = m;
    s = v > 0 ? 1 : (v < 0 ? -1 : 0);
    return clip(v - s * d);
  endfunction

  function automatic point_t predict_fold(input point_t p);
    point_t r;
    longint old_v[3], new_v[3], fold_v[3];
    longint est, col, sum;
    old_v[0] = widen(p.x);
    old_v[1] = widen(p.y);
    old_v[2] = widen(p.z);
    for (int i = 0; i < 3; i++) begin
      fold_v[i] = widen(fold_settings.fold[i][63:32]);
      if (i < 2 || fold_settings.mode.fold_z) begin
        new_v[i] = fold_coord(old_v[i], fold_v[i], widen(fold_settings.fold[i][31:0]));
      end else begin
        new_v[i] = old_v[i];
      end
    end
    est = widen(p.estimate);
    if (fold_settings.mode.rescale) begin
      est = clip(fixed_mul(est, widen(fold_settings.scale[63:32]))
                 + widen(fold_settings.scale[31:0]));
    end
    col = widen(p.colour);
    if (fold_settings.mode.colour_en) begin
      sum = col;
      for (int i = 0; i < 3; i++) begin
        if (new_v[i] != old_v[i]) begin
          if (fold_settings.mode.weighted) begin
            sum += fixed_mul(widen(fold_settings.factor[i]), magnitude(new_v[i]) - fold_v[i]);
          end else begin
            sum += widen(fold_settings.factor[i]);
          end
        end
      end
      col = clip(sum);
    end
    r.x = 32'(new_v[0]);
    r.y = 32'(new_v[1]);
    r.z = 32'(new_v[2]);
    r.estimate = 32'(est);
    r.colour = 32'(col);
    return r;
  endfunction

  function automatic settings_t make_settings(input logic [63:0] fx, input logic [63:0] fy,
                                              input logic [63:0] fz, input sbf3_mode_t md,
                                              input logic [63:0] sc, input logic [31:0] kx,
                                              input logic [31:0] ky, input logic [31:0] kz);
    settings_t s;
    s.fold[0] = fx;
    s.fold[1] = fy;
    s.fold[2] = fz;
    s.mode = md;
    s.scale = sc;
    s.factor[0] = kx;
    s.factor[1] = ky;
    s.factor[2] = kz;
    return s;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] r;
    r = $urandom();
    unique case ($urandom_range(9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3, 4: return r;
      default: return {{4{r[27]}}, r[27:0]};
    endcase
  endfunction

  function automatic logic [31:0] pick_clamp();
    if ($urandom_range(3) == 0) return pick_value();
    return 32'($urandom_range(32'h0400_0000));
  endfunction

  function automatic settings_t random_settings();
    return make_settings({pick_value(), pick_clamp()}, {pick_value(), pick_clamp()},
                         {pick_value(), pick_clamp()},
                         sbf3_mode_t'(4'($urandom_range(15))),
                         {pick_value(), pick_value()}, pick_value(), pick_value(),
                         pick_value());
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (errors < REPORT_LIMIT) $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void add_known(input point_t stim, input point_t want);
    directed_rows.push_back('{preset: 0, typed: 1'b1, stim: stim, want: want});
  endfunction

  function automatic void add_checked(input int preset, input point_t stim);
    directed_rows.push_back('{preset: preset, typed: 1'b0, stim: stim, want: '0});
  endfunction

  task automatic write_reg(input sbf3_reg_t idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    if (prdata !== value) begin
      if (errors < REPORT_LIMIT) $error("prdata: expected %h, got %h", value, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_settings(input settings_t s);
    write_reg(REG_FOLD_X, s.fold[0]);
    write_reg(REG_FOLD_Y, s.fold[1]);
    write_reg(REG_FOLD_Z, s.fold[2]);
    write_reg(REG_MODE, {60'd0, s.mode});
    write_reg(REG_SCALE, s.scale);
    write_reg(REG_COL_X, {32'd0, s.factor[0]});
    write_reg(REG_COL_Y, {32'd0, s.factor[1]});
    write_reg(REG_COL_Z, {32'd0, s.factor[2]});
    fold_settings = s;
    settings_loaded++;
  endtask

  task automatic send_point(input point_t p, input bit typed, input point_t want);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    in_x        <= p.x;
    in_y        <= p.y;
    in_z        <= p.z;
    estimate_in <= p.estimate;
    colour_in   <= p.colour;
    do @(posedge clk); while (busy);
    expected_points.push_back(typed ? want : predict_fold(p));
    points_sent++;
  endtask

  task automatic drain_points();
    @(negedge clk);
    start <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && done) begin
      if (expected_points.size() == 0) begin
        if (errors < REPORT_LIMIT) $error("result transfer with no point outstanding");
        errors++;
      end else begin
        want = expected_points.pop_front();
        check_field("out_x", want.x, out_x);
        check_field("out_y", want.y, out_y);
        check_field("out_z", want.z, out_z);
        check_field("estimate_out", want.estimate, estimate_out);
        check_field("colour_out", want.colour, colour_out);
        points_checked++;
      end
    end
  end

  initial begin
    int active;
    point_t p;
    presets[0] = make_settings(FOLD_RESET, FOLD_RESET, FOLD_RESET, MODE_RESET, SCALE_RESET,
                               '0, '0, '0);
    presets[1] = make_settings({Q_ONE, Q_NEG_ONE}, {32'h0, 32'h0200_0000}, {Q_MIN, Q_MAX},
                               '{weighted: 1'b1, colour_en: 1'b1, rescale: 1'b1, fold_z: 1'b1},
                               {Q_MAX, Q_MIN}, Q_MAX, Q_MIN, Q_ONE);
    presets[2] = make_settings({Q_MIN, 32'h0080_0000}, {Q_NEG_ONE, 32'h0080_0000},
                               {Q_ONE, Q_ONE},
                               '{weighted: 1'b0, colour_en: 1'b1, rescale: 1'b1, fold_z: 1'b0},
                               {Q_MIN, Q_MAX}, Q_MIN, Q_MIN, Q_MIN);
    presets[3] = make_settings('0, '0, '0,
                               '{weighted: 1'b1, colour_en: 1'b1, rescale: 1'b0, fold_z: 1'b1},
                               '0, Q_ONE, Q_NEG_ONE, Q_MAX);
    fold_settings = presets[0];

    // reset defaults: fold 1.0, clamp 2.0, z folded, estimate and colour passed through
    add_known('0, '0);
    add_known('{32'h0300_0000, 32'hFD00_0000, 32'h0180_0000, Q_MAX, Q_MIN},
              '{Q_ONE, Q_NEG_ONE, 32'h0080_0000, Q_MAX, Q_MIN});
    add_known('{Q_MAX, Q_MIN, 32'h0080_0000, Q_MIN, Q_MAX},
              '{32'h7DFF_FFFF, 32'h8200_0000, 32'h0080_0000, Q_MIN, Q_MAX});
    add_known('{Q_ONE, Q_NEG_ONE, 32'hFF80_0000, 32'h1, 32'hFFFF_FFFF},
              '{Q_ONE, Q_NEG_ONE, 32'hFF80_0000, 32'h1, 32'hFFFF_FFFF});
    add_known('{32'h0200_0000, 32'hFE00_0000, 32'h0400_0000, 32'h1234_5678, 32'hEDCB_A988},
              '{32'h0, 32'h0, 32'h0200_0000, 32'h1234_5678, 32'hEDCB_A988});
    add_known('{32'h1, 32'hFFFF_FFFF, 32'h0100_0001, 32'h0, 32'h0},
              '{32'h1, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h0, 32'h0});
    // negative clamp, zero fold, extreme fold, saturating rescale and weighted colour
    add_checked(1, '0);
    add_checked(1, '{Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN});
    add_checked(1, '{Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX});
    add_checked(1, '{32'h0300_0000, 32'hFF80_0000, Q_ONE, Q_ONE, 32'h0});
    add_checked(1, '{32'h0080_0000, 32'h0040_0000, 32'hFE00_0000, Q_NEG_ONE, Q_MAX});
    // z held, plain colour driven to the negative rail
    add_checked(2, '{32'h0300_0000, 32'hFD00_0000, 32'h0700_0000, Q_ONE, Q_MIN});
    add_checked(2, '{Q_MAX, Q_MIN, 32'h0, Q_MAX, 32'h0});
    add_checked(2, '{32'h0, 32'h0, Q_MIN, Q_MIN, Q_MAX});
    // zero fold and clamp: nothing moves, colour passes
    add_checked(3, '{32'h0300_0000, 32'hFD00_0000, Q_MIN, Q_MAX, 32'h5});
    add_checked(3, '{Q_MAX, Q_MIN, 32'h1, 32'h0, Q_MIN});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    active = 0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].preset != active) begin
        drain_points();
        load_settings(presets[directed_rows[i].preset]);
        active = directed_rows[i].preset;
      end
      send_point(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = phase == 0 ? 29 : (phase == 1 ? 88 : 0);
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        drain_points();
        load_settings(seg == 0 ? presets[phase + 1] : random_settings());
        repeat (RANDOM_POINTS / (3 * SEGMENTS)) begin
          p = '{pick_value(), pick_value(), pick_value(), pick_value(), pick_value()};
          send_point(p, 1'b0, '0);
        end
      end
    end

    drain_points();
    repeat (2 * LATENCY) @(posedge clk);
    $display("testbench: %0d points sent, %0d results checked, %0d register sets written and read back",
             points_sent, points_checked, settings_loaded);
    $display("testbench: sender idled at 29, 88 and 0 percent; %0d mismatches", errors);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
